[sv/lfs_pkg.sv]
// Package with the shared constants, types and helpers of the line follower steering block.
`timescale 1ns / 1ps

package lfs_pkg;

  localparam int SENSOR_COUNT = 8;
  localparam int SAMPLE_BITS  = 8;

  localparam int IDX_W   = $clog2(SENSOR_COUNT);
  localparam int CNT_W   = $clog2(SENSOR_COUNT + 1);
  localparam int TOT_W   = $clog2((SENSOR_COUNT * (SENSOR_COUNT - 1)) / 2 + 1);
  localparam int POS_W   = (IDX_W > 3) ? IDX_W : 3;
  localparam int CMP_W   = (SAMPLE_BITS > 8) ? SAMPLE_BITS : 8;
  localparam int STEP_W  = (IDX_W > 1) ? $clog2(IDX_W) : 1;
  localparam int FRAME_W = SENSOR_COUNT * SAMPLE_BITS;
  localparam int IN_W    = ((FRAME_W + 7) / 8) * 8;
  localparam int OUT_W   = 32;

  // Configuration register indexes.
  localparam logic [2:0] CFG_BLACK_THRESHOLD = 3'd0;
  localparam logic [2:0] CFG_FAST_DRIVE      = 3'd1;
  localparam logic [2:0] CFG_SLOW_DRIVE      = 3'd2;
  localparam logic [2:0] CFG_REVERSE_DRIVE   = 3'd3;
  localparam logic [2:0] CFG_GATE_CLOSED_CMD = 3'd4;

  // Hard turn codes.
  localparam logic [1:0] TURN_NONE  = 2'd0;
  localparam logic [1:0] TURN_RIGHT = 2'd1;
  localparam logic [1:0] TURN_LEFT  = 2'd2;

  localparam logic [POS_W-1:0] NO_LINE_POS = POS_W'(3);
  localparam logic [6:0] PCT_MAX = 7'd100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } lfs_state_t;

  typedef struct packed {
    logic [TOT_W-1:0] total;
    logic [CNT_W-1:0] count;
    logic             split;
  } scan_res_t;

  typedef struct packed {
    logic [6:0] fast;
    logic [6:0] slow;
    logic [6:0] rev;
    logic [6:0] gate_closed;
  } drive_cfg_t;

  typedef struct packed {
    logic [7:0] left_drive;
    logic [7:0] right_drive;
    logic [6:0] gate_cmd;
    logic [1:0] turn_mode;
  } steer_out_t;

  // Saturate a 7-bit register value to 100 percent.
  function automatic logic [6:0] pct(input logic [6:0] v);
    pct = (v > PCT_MAX) ? PCT_MAX : v;
  endfunction

endpackage

[sv/lfs_scan.sv]
// Sample scanner: walks the frame one sensor per cycle while en is high and accumulates the black statistics.
`timescale 1ns / 1ps

module lfs_scan
  import lfs_pkg::*;
(
  input  logic               clk,
  input  logic               load,
  input  logic [FRAME_W-1:0] frame_in,
  input  logic               en,
  input  logic [7:0]         threshold,
  output logic               last,
  output scan_res_t          res
);

  logic [FRAME_W-1:0] frame;
  logic [IDX_W-1:0]   idx;
  logic               prev;
  logic               seen_run;
  logic               blk;

  assign blk  = CMP_W'(frame[SAMPLE_BITS-1:0]) > CMP_W'(threshold);
  assign last = (idx == IDX_W'(SENSOR_COUNT - 1));

  always_ff @(posedge clk) begin
    if (load) begin
      frame     <= frame_in;
      idx       <= '0;
      prev      <= 1'b0;
      seen_run  <= 1'b0;
      res.total <= '0;
      res.count <= '0;
      res.split <= 1'b0;
    end else if (en) begin
      frame <= frame >> SAMPLE_BITS;
      idx   <= idx + IDX_W'(1);
      prev  <= blk;
      if (blk) begin
        res.total <= res.total + TOT_W'(idx);
        res.count <= res.count + CNT_W'(1);
        if (!prev) begin
          // A new run of black samples starts here.
          seen_run <= 1'b1;
          if (seen_run) begin
            res.split <= 1'b1;
          end
        end
      end
    end
  end

endmodule

[sv/lfs_div.sv]
// Iterative divider: one quotient bit per cycle, most significant bit first.
`timescale 1ns / 1ps

module lfs_div
  import lfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [TOT_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [IDX_W-1:0] quot
);

  localparam int DW = CNT_W + IDX_W + TOT_W;

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [TOT_W-1:0]  rem;
  logic [DW-1:0]     rem_ext;
  logic [DW-1:0]     trial;
  logic              fits;

  assign rem_ext = DW'(rem);
  assign trial   = DW'(divisor) << step;
  assign fits    = rem_ext >= trial;
  assign done    = busy && (step == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend;
      quot <= '0;
      step <= STEP_W'(IDX_W - 1);
    end else if (busy) begin
      if (fits) begin
        rem <= TOT_W'(rem_ext - trial);
      end
      quot[step[STEP_W-1:0]] <= fits;
      if (step != '0) begin
        step <= step - STEP_W'(1);
      end
    end
  end

endmodule

[sv/lfs_steer.sv]
// Steering decision: drive commands, hard-turn latch and gate servo state.
`timescale 1ns / 1ps

module lfs_steer
  import lfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             update,
  input  logic [POS_W-1:0] pos,
  input  drive_cfg_t       cfg,
  output steer_out_t       nxt
);

  logic [1:0] hard_turn;
  logic       gate_latched;
  logic [6:0] gate_position;
  logic [7:0] last_left_drive;
  logic [7:0] last_right_drive;
  logic       gate_latched_next;

  logic [7:0] fast;
  logic [7:0] slow;
  logic [7:0] neg_rev;
  logic       close_gate;
  logic       straight;
  logic       turn_active;
  logic       centered;

  assign fast        = {1'b0, pct(cfg.fast)};
  assign slow        = {1'b0, pct(cfg.slow)};
  assign neg_rev     = 8'd0 - {1'b0, pct(cfg.rev)};
  assign turn_active = (hard_turn == TURN_RIGHT) || (hard_turn == TURN_LEFT);
  assign centered    = (pos == POS_W'(3)) || (pos == POS_W'(4));

  always_comb begin
    nxt.left_drive    = last_left_drive;
    nxt.right_drive   = last_right_drive;
    nxt.gate_cmd      = gate_position;
    nxt.turn_mode     = hard_turn;
    gate_latched_next = gate_latched;
    close_gate        = 1'b0;
    straight          = 1'b0;
    if (turn_active) begin
      // Hold the turn drive until the line is back near the center.
      if (hard_turn == TURN_RIGHT) begin
        nxt.left_drive  = fast;
        nxt.right_drive = neg_rev;
      end else begin
        nxt.left_drive  = neg_rev;
        nxt.right_drive = fast;
      end
      if (centered) begin
        nxt.turn_mode = TURN_NONE;
      end
    end else begin
      nxt.turn_mode = TURN_NONE;
      case (pos)
        POS_W'(0): begin
          nxt.left_drive  = fast;
          nxt.right_drive = neg_rev;
          close_gate      = 1'b1;
          nxt.turn_mode   = TURN_RIGHT;
        end
        POS_W'(1): begin
          nxt.left_drive  = fast;
          nxt.right_drive = 8'd0;
          close_gate      = 1'b1;
        end
        POS_W'(2): begin
          nxt.left_drive  = fast;
          nxt.right_drive = slow;
          straight        = 1'b1;
        end
        POS_W'(3), POS_W'(4): begin
          nxt.left_drive  = fast;
          nxt.right_drive = fast;
          straight        = 1'b1;
        end
        POS_W'(5): begin
          nxt.left_drive  = slow;
          nxt.right_drive = fast;
          straight        = 1'b1;
        end
        POS_W'(6): begin
          nxt.left_drive  = 8'd0;
          nxt.right_drive = fast;
          close_gate      = 1'b1;
        end
        POS_W'(7): begin
          nxt.left_drive  = neg_rev;
          nxt.right_drive = fast;
          close_gate      = 1'b1;
          nxt.turn_mode   = TURN_LEFT;
        end
        default: begin
        end
      endcase
      if (close_gate) begin
        nxt.gate_cmd      = pct(cfg.gate_closed);
        gate_latched_next = 1'b1;
      end
      if (gate_latched && straight) begin
        nxt.gate_cmd = 7'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hard_turn        <= TURN_NONE;
      gate_latched     <= 1'b0;
      gate_position    <= 7'd0;
      last_left_drive  <= 8'd0;
      last_right_drive <= 8'd0;
    end else if (update) begin
      hard_turn        <= nxt.turn_mode;
      gate_latched     <= gate_latched_next;
      gate_position    <= nxt.gate_cmd;
      last_left_drive  <= nxt.left_drive;
      last_right_drive <= nxt.right_drive;
    end
  end

endmodule

[sv/line_follower_steering.sv]
// Top level of the line follower steering block: handshakes, configuration and sequencing.
`timescale 1ns / 1ps
//
// Usage. Each input item on the s_ channel is one frame of eight reflectance
// samples, sample_0 (rightmost) in the low byte of s_tdata. Each frame yields
// exactly one result item on the m_ channel: the line position, the line
// flags, the left and right drive commands, the gate servo command and the
// hard-turn mode that holds after this frame.
// Configuration registers are written through cfg_we, cfg_addr and cfg_data
// while the block is idle; index 0 is the black threshold, 1 to 3 the fast,
// slow and reverse drive percents and 4 the gate closed command.
// Timing. An item is taken while the block is idle, the samples are then
// compared one per cycle, the mean index comes out of a divider that
// produces one quotient bit per cycle after a load step, and the decision
// is then written to the output register once it is free. A new item is
// taken only after the result of the last one has been written to the
// output register; the serial sample scan and the divider set the pace.
// Stalls. The output register holds a finished result while the receiver
// stalls, and the block goes on accepting and scanning the next frame; it
// only waits in its final step until the output register is free.
// Reset. The synchronous reset returns the registers to their defaults,
// clears the turn, gate and drive state and empties the output register.

module line_follower_steering
  import lfs_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  // s_tdata fields, lowest bit up: sample_0 .. sample_7, 8 bits each.
  input  logic [IN_W-1:0] s_tdata,
  input  logic            s_tvalid,
  output logic            s_tready,
  // m_tdata fields, lowest bit up: line_position (3), line_found, line_split,
  // line_thick, left_drive (8), right_drive (8), gate_cmd (7), turn_mode (2),
  // one zero fill bit.
  output logic [OUT_W-1:0] m_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_addr,
  input  logic [7:0]       cfg_data
);

  lfs_state_t state;
  lfs_state_t state_next;

  logic [7:0] black_threshold;
  drive_cfg_t dcfg;

  logic             scan_load;
  logic             scan_en;
  logic             scan_last;
  scan_res_t        scan_res;
  logic             div_start;
  logic             div_done;
  logic [IDX_W-1:0] quot;
  logic             emit;
  logic             found;
  logic [POS_W-1:0] pos;
  steer_out_t       steer_nxt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      black_threshold  <= 8'd77;
      dcfg.fast        <= 7'd50;
      dcfg.slow        <= 7'd20;
      dcfg.rev         <= 7'd20;
      dcfg.gate_closed <= 7'd70;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_BLACK_THRESHOLD: black_threshold  <= cfg_data;
        CFG_FAST_DRIVE:      dcfg.fast        <= cfg_data[6:0];
        CFG_SLOW_DRIVE:      dcfg.slow        <= cfg_data[6:0];
        CFG_REVERSE_DRIVE:   dcfg.rev         <= cfg_data[6:0];
        CFG_GATE_CLOSED_CMD: dcfg.gate_closed <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    scan_en   = 1'b0;
    div_start = 1'b0;
    emit      = 1'b0;
    case (state)
      ST_IDLE: s_tready  = 1'b1;
      ST_SCAN: scan_en   = 1'b1;
      ST_LOAD: div_start = 1'b1;
      ST_EMIT: emit      = !m_tvalid || m_tready;
      default: begin
      end
    endcase
  end

  assign scan_load = s_tvalid && s_tready;

  lfs_scan u_scan (
    .clk       (clk),
    .load      (scan_load),
    .frame_in  (s_tdata[FRAME_W-1:0]),
    .en        (scan_en),
    .threshold (black_threshold),
    .last      (scan_last),
    .res       (scan_res)
  );

  lfs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (scan_res.total),
    .divisor  (scan_res.count),
    .done     (div_done),
    .quot     (quot)
  );

  // An empty frame reads as the center position.
  assign found = (scan_res.count != '0);
  assign pos   = found ? POS_W'(quot) : NO_LINE_POS;

  lfs_steer u_steer (
    .clk    (clk),
    .rst    (rst),
    .update (emit),
    .pos    (pos),
    .cfg    (dcfg),
    .nxt    (steer_nxt)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {1'b0,
                  steer_nxt.turn_mode,
                  steer_nxt.gate_cmd,
                  steer_nxt.right_drive,
                  steer_nxt.left_drive,
                  (scan_res.count > CNT_W'(2)),
                  scan_res.split,
                  found,
                  3'(pos)};
    end
  end

  // An accepted frame always starts the sample scan.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_SCAN))
    else $error("accepted item did not start the scan");

  // The turn mode code without meaning never leaves the block.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[30:29] != 2'd3))
    else $error("invalid turn mode on output");

  // Without a line the position reads as the center.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[3]) |-> (m_tdata[2:0] == 3'd3))
    else $error("empty frame gave a position other than center");

  // A split or thick line implies a line was found.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[4] || m_tdata[5])) |-> m_tdata[3])
    else $error("line flags set without a line");

endmodule
